>>> rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/tpo_pkg.sv
// Types and constants for the triangle pair overlap test.
// No dependencies.
package tpo_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int ProdW  = 34;
  localparam int CrossW = 35;
  localparam int NumTests = 15;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;

  // One ratio test: den and two numerators
  typedef struct packed {
    diff_t ax, ay, bx, by, cx, cy;   // d = a x b, n0 = c x b, n1 = a x c
  } diffs_t;

  typedef struct packed {
    prod_t d0, d1, n00, n01, n10, n11;
  } prods_t;

  typedef struct packed {
    cross_t d, n0, n1;
  } crosses_t;

  typedef struct packed {
    coord_t x0, y0, x1, y1, x2, y2;
  } tri_t;

endpackage

>>> rtl/triangle_pair_overlap_test.sv
// Top level of the triangle pair overlap test.
// Depends on tpo_pkg, tpo_front, tpo_test_unit and assert_macros.svh.
`include "assert_macros.svh"

// Accepts one triangle pair per cycle while the pipeline advances and
// returns one overlap flag per pair. The five-stage pipeline (differences,
// products, cross products, range checks, OR reduction) advances as a whole
// whenever its output register is empty or being taken.
module triangle_pair_overlap_test
  import tpo_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_x0,y0,x1,y1,x2,y2, second_x0,y0,x1,y1,x2,y2 (16 bits each)
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // overlap in bit 0, zero padded
  output logic [7:0]   m_tdata
);

  localparam int Depth = 5;

  logic [Depth-1:0] vld;
  logic             en;
  tri_t             ta, tb;
  diffs_t           diffs [NumTests];
  logic [NumTests-1:0] hits;
  logic             overlap;

  assign en       = !vld[Depth-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[Depth-1];
  assign m_tdata  = {7'b0, overlap};

  assign ta = '{s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                s_tdata[63:48], s_tdata[79:64], s_tdata[95:80]};
  assign tb = '{s_tdata[111:96], s_tdata[127:112], s_tdata[143:128],
                s_tdata[159:144], s_tdata[175:160], s_tdata[191:176]};

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], s_tvalid};
    end
  end

  tpo_front u_front (.clk, .en, .ta, .tb, .diffs);

  for (genvar k = 0; k < NumTests; k++) begin : g_test
    tpo_test_unit u_test (
      .clk, .en, .tri_mode(k < 6), .diffs(diffs[k]), .hit(hits[k])
    );
  end

  // reduce the fifteen tests
  always_ff @(posedge clk) begin
    if (en) overlap <= |hits;
  end

  `ASSERT_IMPL(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)
  `ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPL(a_pad_zero, clk, rst, m_tvalid, m_tdata[7:1] == 7'b0)

endmodule

>>> rtl/tpo_test_unit.sv
// Pipelined ratio test: products, crosses, sign-normalised range check.
// Depends on tpo_pkg. Three register stages, stall by enable.
module tpo_test_unit
  import tpo_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  logic   tri_mode,   // 1: point in triangle, 0: segment crossing
  input  diffs_t diffs,
  output logic   hit
);

  prods_t   prods;
  crosses_t cr;
  logic     mode1, mode2;
  cross_t   dn, n0n, n1n;
  logic signed [CrossW+1:0] r;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      prods.d0  <= diffs.ax * diffs.by;
      prods.d1  <= diffs.ay * diffs.bx;
      prods.n00 <= diffs.cx * diffs.by;
      prods.n01 <= diffs.cy * diffs.bx;
      prods.n10 <= diffs.ax * diffs.cy;
      prods.n11 <= diffs.ay * diffs.cx;
      mode1     <= tri_mode;
    end
  end

  // stage 2: cross products; the segment's second numerator is c x a
  always_ff @(posedge clk) begin
    if (en) begin
      cr.d  <= CrossW'(prods.d0) - CrossW'(prods.d1);
      cr.n0 <= CrossW'(prods.n00) - CrossW'(prods.n01);
      cr.n1 <= mode1 ? CrossW'(prods.n10) - CrossW'(prods.n11)
                     : CrossW'(prods.n11) - CrossW'(prods.n10);
      mode2 <= mode1;
    end
  end

  // stage 3: make denominator positive and check ranges
  always_comb begin
    dn  = cr.d[CrossW-1] ? -cr.d : cr.d;
    n0n = cr.d[CrossW-1] ? -cr.n0 : cr.n0;
    n1n = cr.d[CrossW-1] ? -cr.n1 : cr.n1;
    r   = (CrossW+2)'(dn) - (CrossW+2)'(n0n) - (CrossW+2)'(n1n);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= (cr.d != '0) && !n0n[CrossW-1] && (n0n <= dn)
             && !n1n[CrossW-1] && (n1n <= dn)
             && (!mode2 || (!r[CrossW+1] && (r <= (CrossW+2)'(dn))));
    end
  end

endmodule

>>> rtl/tpo_front.sv
// Input stage: edge and offset differences for all fifteen tests.
// Depends on tpo_pkg.
module tpo_front
  import tpo_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  tri_t   ta,
  input  tri_t   tb,
  output diffs_t diffs [NumTests]
);

  coord_t axv [3], ayv [3], bxv [3], byv [3];
  diffs_t d_next [NumTests];

  function automatic diff_t sub(coord_t p, coord_t q);
    return diff_t'(p) - diff_t'(q);
  endfunction

  always_comb begin
    axv = '{ta.x0, ta.x1, ta.x2}; ayv = '{ta.y0, ta.y1, ta.y2};
    bxv = '{tb.x0, tb.x1, tb.x2}; byv = '{tb.y0, tb.y1, tb.y2};
    // vertices of b in a, then of a in b
    for (int i = 0; i < 3; i++) begin
      d_next[i] = '{sub(axv[1], axv[0]), sub(ayv[1], ayv[0]),
                    sub(axv[2], axv[0]), sub(ayv[2], ayv[0]),
                    sub(bxv[i], axv[0]), sub(byv[i], ayv[0])};
      d_next[3+i] = '{sub(bxv[1], bxv[0]), sub(byv[1], byv[0]),
                      sub(bxv[2], bxv[0]), sub(byv[2], byv[0]),
                      sub(axv[i], bxv[0]), sub(ayv[i], byv[0])};
    end
    // edge pairs: den = da x db, tn = w x db, un = w x da with w = a0 - b0
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        d_next[6+3*i+j] = '{sub(axv[i], axv[(i+1)%3]), sub(ayv[i], ayv[(i+1)%3]),
                            sub(bxv[j], bxv[(j+1)%3]), sub(byv[j], byv[(j+1)%3]),
                            sub(axv[i], bxv[j]), sub(ayv[i], byv[j])};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) diffs <= d_next;
  end

endmodule

>>> test/overlap_checker.sv
// Checker for the triangle pair overlap block: watches both stream channels,
// computes the expected overlap flag per accepted pair and compares results.
// Depends on tpo_pkg for coordinate widths.
module overlap_checker
  import tpo_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [7:0]   m_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic expected_flags [int];
  int   wr_count = 0;
  int   rd_count = 0;

  assign pending = wr_count - rd_count;

  // Point in triangle by exact barycentric comparison, boundary included
  function automatic bit inside_tri(longint px[3], longint py[3], longint qx, longint qy);
    longint d, u, v, r;
    d = (px[1]-px[0])*(py[2]-py[0]) - (py[1]-py[0])*(px[2]-px[0]);
    u = (qx-px[0])*(py[2]-py[0]) - (qy-py[0])*(px[2]-px[0]);
    v = (px[1]-px[0])*(qy-py[0]) - (py[1]-py[0])*(qx-px[0]);
    if (d == 0) return 0;
    if (d < 0) begin
      d = -d; u = -u; v = -v;
    end
    r = d - u - v;
    return u >= 0 && u <= d && v >= 0 && v <= d && r >= 0 && r <= d;
  endfunction

  // Segment crossing, ends included; parallel never crosses
  function automatic bit edges_cross(longint a0x, longint a0y, longint a1x, longint a1y,
                                     longint b0x, longint b0y, longint b1x, longint b1y);
    longint dax, day, dbx, dby, den, tn, un;
    dax = a0x - a1x; day = a0y - a1y;
    dbx = b0x - b1x; dby = b0y - b1y;
    den = dax*dby - day*dbx;
    tn = (a0x-b0x)*dby - (a0y-b0y)*dbx;
    un = -(dax*(a0y-b0y) - day*(a0x-b0x));
    if (den == 0) return 0;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    return tn >= 0 && tn <= den && un >= 0 && un <= den;
  endfunction

  function automatic bit pair_overlaps(logic [191:0] pair);
    longint ax[3], ay[3], bx[3], by[3];
    bit hit;
    hit = 0;
    for (int i = 0; i < 3; i++) begin
      ax[i] = longint'(coord_t'(pair[32*i +: 16]));
      ay[i] = longint'(coord_t'(pair[32*i+16 +: 16]));
      bx[i] = longint'(coord_t'(pair[96+32*i +: 16]));
      by[i] = longint'(coord_t'(pair[96+32*i+16 +: 16]));
    end
    for (int i = 0; i < 3; i++)
      if (inside_tri(ax, ay, bx[i], by[i]) || inside_tri(bx, by, ax[i], ay[i])) hit = 1;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (edges_cross(ax[i], ay[i], ax[(i+1)%3], ay[(i+1)%3],
                        bx[j], by[j], bx[(j+1)%3], by[(j+1)%3])) hit = 1;
    return hit;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Requests in, results out
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_flags[wr_count] = pair_overlaps(s_tdata);
        wr_count++;
      end
      if (m_tvalid && m_tready) begin
        if (wr_count == rd_count) begin
          report_mismatch("result with no request outstanding");
        end else begin
          logic want;
          want = expected_flags[rd_count];
          expected_flags.delete(rd_count);
          rd_count++;
          if (m_tdata !== {7'd0, want})
            report_mismatch($sformatf("overlap got %h want %0d", m_tdata, want));
        end
      end
    end
  end
endmodule

>>> test/testbench.sv
// Stimulus and verdict for the triangle pair overlap block.
// Depends on tpo_pkg, triangle_pair_overlap_test and overlap_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tpo_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [7:0]   m_tdata;
  int           fail_count, pending;
  int           send_idle = 0, recv_stall = 0;
  bit           hold_off = 0;
  int           quiet = 0;

  localparam int WatchdogLimit = 5000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  triangle_pair_overlap_test uut (.*);
  overlap_checker chk (.*);

  // Receiver readiness: random stall or a long hold-off
  always @(posedge clk)
    m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'(int'($urandom_range(40)) - 20);
      1: return 16'(int'($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [191:0] random_pair();
    logic [191:0] p;
    int mode;
    mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(1) ? 1 : 2);
    for (int k = 0; k < 12; k++) p[16*k +: 16] = rand_coord(mode);
    // sometimes repeat a vertex or make an axis-aligned edge
    if ($urandom_range(7) == 0) p[127:96] = p[31:0];
    if ($urandom_range(7) == 0) p[63:48] = p[31:16];
    return p;
  endfunction

  // Offers one request, with the sender's random idle gap in front;
  // tvalid stays high into the next request when there is no gap
  task automatic send_pair(logic [191:0] p);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= p;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [191:0] tri_pair(int a[6], int b[6]);
    logic [191:0] p;
    for (int k = 0; k < 6; k++) begin
      p[16*k +: 16]      = 16'(a[k]);
      p[96+16*k +: 16]   = 16'(b[k]);
    end
    return p;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: nested, touching corner, shared edge, crossing, apart,
    // degenerate triangle, collinear edges, coordinate extremes
    send_pair(tri_pair('{0,0,100,0,0,100}, '{10,10,20,10,10,20}));
    send_pair(tri_pair('{10,10,20,10,10,20}, '{0,0,100,0,0,100}));
    send_pair(tri_pair('{0,0,10,0,0,10}, '{10,0,20,0,10,10}));
    send_pair(tri_pair('{0,0,10,0,0,10}, '{0,0,10,0,0,-10}));
    send_pair(tri_pair('{0,0,10,0,5,10}, '{0,5,10,5,5,-5}));
    send_pair(tri_pair('{0,0,10,0,0,10}, '{20,20,30,20,20,30}));
    send_pair(tri_pair('{0,0,5,5,10,10}, '{0,0,10,0,0,10}));
    send_pair(tri_pair('{0,0,5,5,10,10}, '{3,3,3,3,3,3}));
    send_pair(tri_pair('{0,0,10,0,20,0}, '{5,0,15,0,5,0}));
    send_pair(tri_pair('{-32768,-32768,32767,-32768,-32768,32767},
                       '{0,0,1,0,0,1}));
    send_pair(tri_pair('{32767,32767,32767,-32768,-32768,32767},
                       '{-32768,-32768,32767,-32768,-32768,32767}));
    send_pair(tri_pair('{-32768,-32768,-32768,-32768,-32768,-32768},
                       '{32767,32767,32767,32767,32767,32767}));
    send_pair({192{1'b1}});
    send_pair({96{2'b10}});
    send_pair({96{2'b01}});
    send_pair(tri_pair('{0,0,10,0,0,10}, '{5,5,15,5,5,15}));

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 3 ? 21 : 57) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 21 : 57) : 0;
      for (int n = 0; n < 200; n++) send_pair(random_pair());
    end

    // Long receiver hold-off while requests keep coming
    send_idle = 0; recv_stall = 0;
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      for (int n = 0; n < 80; n++) send_pair(random_pair());
    join
    s_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/tpo_pkg.sv
rtl/tpo_test_unit.sv
rtl/tpo_front.sv
rtl/triangle_pair_overlap_test.sv
test/overlap_checker.sv
test/testbench.sv
